/* sv/apbf_pkg.sv */
// apbf_pkg: shared types, codes and defaults for the address/port blacklist filter
// no dependencies
`timescale 1ns / 1ps

package apbf_pkg;

  localparam int APBF_ENTRIES        = 16;
  localparam int APBF_ADDRESS_OFFSET = 30;
  localparam int APBF_PORT_OFFSET    = 36;

  localparam int          POS_W   = 6;
  localparam logic [5:0]  POS_MAX = 6'd63;

  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_BYTE = 1'b1;

  localparam logic KIND_ADD     = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  typedef struct packed {
    logic [31:0] addr;
    logic [15:0] port;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  function automatic logic entry_hit(input entry_t e, input entry_t c);
    entry_hit = ((e.addr != 32'd0) && (e.addr == c.addr)) ||
                ((e.port != 16'd0) && (e.port == c.port));
  endfunction

endpackage

/* sv/apbf_if.sv */
// apbf_in_if / apbf_out_if: valid/ready channels of the blacklist filter
// no dependencies
`timescale 1ns / 1ps

interface apbf_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [31:0] entry_address;
  logic [15:0] entry_port;
  logic [7:0]  packet_byte;
  logic        packet_last;

  modport source (output valid, opcode, entry_address, entry_port, packet_byte, packet_last,
                  input ready);
  modport sink   (input valid, opcode, entry_address, entry_port, packet_byte, packet_last,
                  output ready);
endinterface

interface apbf_out_if;
  logic valid;
  logic ready;
  logic result_kind;
  logic add_accepted;
  logic packet_passes;

  modport source (output valid, result_kind, add_accepted, packet_passes, input ready);
  modport sink   (input valid, result_kind, add_accepted, packet_passes, output ready);
endinterface

/* sv/apbf_capture.sv */
// apbf_capture: frame byte position and big-endian address/port field capture
// depends on apbf_pkg
`timescale 1ns / 1ps

module apbf_capture import apbf_pkg::*; #(
  parameter int ADDRESS_OFFSET = APBF_ADDRESS_OFFSET,
  parameter int PORT_OFFSET    = APBF_PORT_OFFSET
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       byte_en,
  input  logic [7:0] packet_byte,
  input  logic       packet_last,
  output entry_t     cap
);

  logic [POS_W-1:0] pos_r;
  logic [POS_W-1:0] pos_nxt;
  entry_t           cap_r;
  entry_t           cap_nxt;

  always_comb begin
    cap_nxt = (pos_r == '0) ? '0 : cap_r;
    for (int k = 0; k < 4; k++) begin
      if (pos_r == POS_W'(ADDRESS_OFFSET + k)) begin
        cap_nxt.addr[8*(3-k) +: 8] = packet_byte;
      end
    end
    for (int k = 0; k < 2; k++) begin
      if (pos_r == POS_W'(PORT_OFFSET + k)) begin
        cap_nxt.port[8*(1-k) +: 8] = packet_byte;
      end
    end
    if (packet_last) begin
      pos_nxt = '0;
    end else if (pos_r != POS_MAX) begin
      pos_nxt = pos_r + POS_W'(1);
    end else begin
      pos_nxt = pos_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      cap_r <= '0;
    end else if (byte_en) begin
      pos_r <= pos_nxt;
      cap_r <= cap_nxt;
    end
  end

  assign cap = cap_r;

endmodule

/* sv/address_port_blacklist_filter.sv */
// address_port_blacklist_filter: top level, blacklist table memory and match scan
// depends on apbf_pkg, apbf_if, apbf_capture
//
// Use: words enter on in_ch. An add word (opcode 0) stores its address and port
// in the next free table entry, unless the table is full or both are zero, and
// returns one add status word. A byte word (opcode 1) carries one frame byte;
// only the last byte of a frame returns a verdict word (pass or blocked). Results
// leave on out_ch through an output register.
// Timing: an add status is registered and appears in the cycle after acceptance.
// A verdict appears in the cycle after the last byte when the table is empty,
// otherwise after a scan of the stored entries and the done state: the table sits
// in a memory with one read port that is scanned one entry per cycle.
// Throughput: one add or non-last byte per cycle; no word is taken during a
// verdict scan or its done state.
// Reset empties the table by clearing its fill count and clears the frame
// position and captured fields; no memory sweep is needed. While out_ch stalls
// with a result waiting, no new word is accepted.
`timescale 1ns / 1ps

module address_port_blacklist_filter import apbf_pkg::*; #(
  parameter int FILTER_ENTRIES = APBF_ENTRIES,
  parameter int ADDRESS_OFFSET = APBF_ADDRESS_OFFSET,
  parameter int PORT_OFFSET    = APBF_PORT_OFFSET
) (
  input logic        clk,
  input logic        rst_n,
  apbf_in_if.sink    in_ch,
  apbf_out_if.source out_ch
);

  localparam int IDX_W = (FILTER_ENTRIES > 1) ? $clog2(FILTER_ENTRIES) : 1;
  localparam int CNT_W = $clog2(FILTER_ENTRIES + 1);

  entry_t mem [FILTER_ENTRIES];

  state_t           state_r;
  state_t           state_nxt;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_m1;
  logic [IDX_W-1:0] idx_r;
  logic             rd_pend_r;
  entry_t           rd_data_r;
  logic             hit_r;
  logic             out_valid_r;
  logic             out_kind_r;
  logic             out_add_ok_r;
  logic             out_pass_r;

  logic   in_ready;
  logic   in_fire;
  logic   add_fire;
  logic   byte_fire;
  logic   last_fire;
  logic   table_free;
  logic   add_nonzero;
  logic   cur_hit;
  entry_t cap;

  assign in_ready    = (state_r == ST_IDLE) && (!out_valid_r || out_ch.ready);
  assign in_fire     = in_ch.valid && in_ready;
  assign add_fire    = in_fire && (in_ch.opcode == OP_ADD);
  assign byte_fire   = in_fire && (in_ch.opcode == OP_BYTE);
  assign last_fire   = byte_fire && in_ch.packet_last;
  assign table_free  = (count_r != CNT_W'(FILTER_ENTRIES));
  assign add_nonzero = (in_ch.entry_address != 32'd0) || (in_ch.entry_port != 16'd0);
  assign count_m1    = count_r - CNT_W'(1);
  assign cur_hit     = rd_pend_r && entry_hit(rd_data_r, cap);

  apbf_capture #(
    .ADDRESS_OFFSET (ADDRESS_OFFSET),
    .PORT_OFFSET    (PORT_OFFSET)
  ) u_capture (
    .clk         (clk),
    .rst_n       (rst_n),
    .byte_en     (byte_fire),
    .packet_byte (in_ch.packet_byte),
    .packet_last (in_ch.packet_last),
    .cap         (cap)
  );

  // table memory
  always_ff @(posedge clk) begin
    if (add_fire && table_free && add_nonzero) begin
      mem[count_r[IDX_W-1:0]] <= '{addr: in_ch.entry_address, port: in_ch.entry_port};
    end
    rd_data_r <= mem[idx_r];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (last_fire && (count_r != '0)) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (idx_r == count_m1[IDX_W-1:0]) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      rd_pend_r   <= 1'b0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rd_pend_r <= (state_r == ST_SCAN);
      if (state_r == ST_SCAN) begin
        idx_r <= idx_r + IDX_W'(1);
        hit_r <= hit_r | cur_hit;
      end else begin
        idx_r <= '0;
        hit_r <= 1'b0;
      end
      if (add_fire) begin
        out_valid_r  <= 1'b1;
        out_kind_r   <= KIND_ADD;
        out_add_ok_r <= table_free;
        out_pass_r   <= 1'b0;
        if (table_free && add_nonzero) begin
          count_r <= count_r + CNT_W'(1);
        end
      end else if (last_fire && (count_r == '0)) begin
        out_valid_r  <= 1'b1;
        out_kind_r   <= KIND_VERDICT;
        out_add_ok_r <= 1'b0;
        out_pass_r   <= 1'b1;
      end else if (state_r == ST_DONE) begin
        out_valid_r  <= 1'b1;
        out_kind_r   <= KIND_VERDICT;
        out_add_ok_r <= 1'b0;
        out_pass_r   <= !(hit_r | cur_hit);
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign in_ch.ready          = in_ready;
  assign out_ch.valid         = out_valid_r;
  assign out_ch.result_kind   = out_kind_r;
  assign out_ch.add_accepted  = out_add_ok_r;
  assign out_ch.packet_passes = out_pass_r;

endmodule

/* sv/apbf_checker.sv */
// apbf_checker: port-level assertions for the blacklist filter, bound to the top level
// depends on apbf_pkg, address_port_blacklist_filter
`timescale 1ns / 1ps

module apbf_checker import apbf_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic in_opcode,
  input logic out_valid,
  input logic out_ready,
  input logic out_result_kind,
  input logic out_add_accepted,
  input logic out_packet_passes
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable({out_result_kind, out_add_accepted, out_packet_passes}))
    else $error("result word changed while stalled");

  a_add_no_pass: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result_kind == KIND_ADD) |-> !out_packet_passes)
    else $error("add status carries a pass flag");

  a_verdict_no_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result_kind == KIND_VERDICT) |-> !out_add_accepted)
    else $error("verdict carries an add flag");

  // add status follows its add word at once
  a_add_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_opcode == OP_ADD) |=>
      out_valid && (out_result_kind == KIND_ADD))
    else $error("add status missing one cycle after add");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind address_port_blacklist_filter apbf_checker u_apbf_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .in_opcode         (in_ch.opcode),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_result_kind   (out_ch.result_kind),
  .out_add_accepted  (out_ch.add_accepted),
  .out_packet_passes (out_ch.packet_passes)
);

/* tb/sv/tb_address_port_blacklist_filter.sv */
// tb_address_port_blacklist_filter: self-checking bench for the address/port blacklist filter,
// with a scoreboard class that tracks the table and frame captures and checks each result word
// depends on apbf_pkg, apbf_if and address_port_blacklist_filter
`timescale 1ns / 1ps

import apbf_pkg::*;

typedef struct packed {
  logic        opcode;
  logic [31:0] addr;
  logic [15:0] port;
  logic [7:0]  pkt_byte;
  logic        last;
} filter_word_t;

typedef struct packed {
  logic kind;
  logic accepted;
  logic passes;
} filter_result_t;

class blacklist_scoreboard;
  logic [31:0]      table_addr [APBF_ENTRIES];
  logic [15:0]      table_port [APBF_ENTRIES];
  logic [POS_W-1:0] frame_pos;
  logic [31:0]      grabbed_addr;
  logic [15:0]      grabbed_port;
  filter_result_t   expected_results [$];
  int               errors;

  function new();
    foreach (table_addr[i]) begin
      table_addr[i] = '0;
      table_port[i] = '0;
    end
    frame_pos    = '0;
    grabbed_addr = '0;
    grabbed_port = '0;
    errors       = 0;
  endfunction

  function int pending();
    return expected_results.size();
  endfunction

  function logic store_entry(logic [31:0] a, logic [15:0] p);
    for (int i = 0; i < APBF_ENTRIES; i++) begin
      if (table_addr[i] == '0 && table_port[i] == '0) begin
        table_addr[i] = a;
        table_port[i] = p;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function void grab_byte(logic [7:0] b);
    int rel;
    rel = int'(frame_pos) - APBF_ADDRESS_OFFSET;
    if (rel >= 0 && rel < 4) grabbed_addr[8*(3-rel) +: 8] = b;
    rel = int'(frame_pos) - APBF_PORT_OFFSET;
    if (rel >= 0 && rel < 2) grabbed_port[8*(1-rel) +: 8] = b;
  endfunction

  function logic frame_clear();
    for (int i = 0; i < APBF_ENTRIES; i++) begin
      if (table_addr[i] != '0 && table_addr[i] == grabbed_addr) return 1'b0;
      if (table_port[i] != '0 && table_port[i] == grabbed_port) return 1'b0;
    end
    return 1'b1;
  endfunction

  function void note_word(filter_word_t w);
    filter_result_t r;
    if (w.opcode == OP_ADD) begin
      r.kind     = KIND_ADD;
      r.accepted = store_entry(w.addr, w.port);
      r.passes   = 1'b0;
      expected_results.push_back(r);
      return;
    end
    // frame start clears the captures
    if (frame_pos == '0) begin
      grabbed_addr = '0;
      grabbed_port = '0;
    end
    grab_byte(w.pkt_byte);
    if (!w.last) begin
      if (frame_pos != POS_MAX) frame_pos++;
      return;
    end
    frame_pos  = '0;
    r.kind     = KIND_VERDICT;
    r.accepted = 1'b0;
    r.passes   = frame_clear();
    expected_results.push_back(r);
  endfunction

  function void check_result(logic kind, logic accepted, logic passes);
    filter_result_t want;
    if (expected_results.size() == 0) begin
      $error("unexpected result word: result_kind %0b", kind);
      errors++;
      return;
    end
    want = expected_results.pop_front();
    if (kind !== want.kind) begin
      $error("result_kind: expected %0b, got %0b", want.kind, kind);
      errors++;
    end
    if (accepted !== want.accepted) begin
      $error("add_accepted: expected %0b, got %0b", want.accepted, accepted);
      errors++;
    end
    if (passes !== want.passes) begin
      $error("packet_passes: expected %0b, got %0b", want.passes, passes);
      errors++;
    end
  endfunction
endclass

module tb_address_port_blacklist_filter;

  localparam int HALF_PERIOD = 5;
  localparam int WORD_TARGET = 1900;
  localparam int STALL_LIMIT = 3000;
  localparam int LONG_HOLD   = 600;

  logic clk = 1'b0;
  logic rst_n;

  apbf_in_if  in_ch ();
  apbf_out_if out_ch ();

  address_port_blacklist_filter DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  blacklist_scoreboard scoreboard = new();

  logic [31:0] listed_addrs [$];
  logic [15:0] listed_ports [$];
  int          words_sent = 0;
  int          sender_run_left = 0;
  bit          sender_calm = 1'b0;

  always #HALF_PERIOD clk = ~clk;

  function automatic filter_word_t random_word();
    filter_word_t w;
    w.opcode   = 1'($urandom_range(0, 1));
    w.addr     = $urandom;
    w.port     = 16'($urandom_range(0, 65535));
    w.pkt_byte = 8'($urandom_range(0, 255));
    w.last     = 1'($urandom_range(0, 1));
    return w;
  endfunction

  function automatic filter_word_t add_word(logic [31:0] a, logic [15:0] p);
    filter_word_t w;
    w        = random_word();
    w.opcode = OP_ADD;
    w.addr   = a;
    w.port   = p;
    listed_addrs.push_back(a);
    listed_ports.push_back(p);
    return w;
  endfunction

  function automatic filter_word_t make_add();
    logic [31:0] a;
    logic [15:0] p;
    a = $urandom;
    p = 16'($urandom_range(0, 65535));
    case ($urandom_range(0, 9))
      0: begin
        a = '0;
        p = '0;
      end
      1: a = '0;
      2: p = '0;
      3: begin
        a = '1;
        p = '1;
      end
      4: if (listed_addrs.size() > 0) a = listed_addrs[$urandom_range(0, listed_addrs.size() - 1)];
      default: ;
    endcase
    return add_word(a, p);
  endfunction

  function automatic logic [31:0] pick_frame_addr();
    case ($urandom_range(0, 5))
      0, 1: if (listed_addrs.size() > 0)
        return listed_addrs[$urandom_range(0, listed_addrs.size() - 1)];
      2: return '0;
      3: return '1;
      default: ;
    endcase
    return $urandom;
  endfunction

  function automatic logic [15:0] pick_frame_port();
    case ($urandom_range(0, 5))
      0, 1: if (listed_ports.size() > 0)
        return listed_ports[$urandom_range(0, listed_ports.size() - 1)];
      2: return '0;
      3: return '1;
      default: ;
    endcase
    return 16'($urandom_range(0, 65535));
  endfunction

  // mostly frames that reach both fields, some short or running past the position limit
  function automatic int pick_frame_len();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 15) return $urandom_range(1, 29);
    if (sel < 30) return $urandom_range(31, 37);
    if (sel < 85) return $urandom_range(38, 48);
    return $urandom_range(60, 80);
  endfunction

  task automatic send_word(filter_word_t w);
    int gap;
    if (sender_run_left == 0) begin
      sender_calm     = ($urandom_range(0, 3) == 0);
      sender_run_left = $urandom_range(10, 60);
    end
    sender_run_left--;
    gap = sender_calm ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.opcode        <= w.opcode;
    in_ch.entry_address <= w.addr;
    in_ch.entry_port    <= w.port;
    in_ch.packet_byte   <= w.pkt_byte;
    in_ch.packet_last   <= w.last;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    scoreboard.note_word(w);
    words_sent++;
  endtask

  task automatic send_frame(int len, logic [31:0] fa, logic [15:0] fp);
    filter_word_t w;
    int rel;
    for (int pos = 0; pos < len; pos++) begin
      // occasional add in the middle of a frame
      if ($urandom_range(0, 99) < 2) send_word(make_add());
      w        = random_word();
      w.opcode = OP_BYTE;
      w.last   = (pos == len - 1);
      rel = pos - APBF_ADDRESS_OFFSET;
      if (rel >= 0 && rel < 4) w.pkt_byte = fa[8*(3-rel) +: 8];
      rel = pos - APBF_PORT_OFFSET;
      if (rel >= 0 && rel < 2) w.pkt_byte = fp[8*(1-rel) +: 8];
      send_word(w);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
      scoreboard.check_result(out_ch.result_kind, out_ch.add_accepted, out_ch.packet_passes);
  end

  initial begin : result_sink
    int stall;
    int seen;
    int run_left;
    bit calm;
    out_ch.ready <= 1'b0;
    seen     = 0;
    run_left = 0;
    calm     = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (run_left == 0) begin
        calm     = ($urandom_range(0, 3) == 0);
        run_left = $urandom_range(5, 20);
      end
      run_left--;
      stall = calm ? 0 : $urandom_range(0, 18);
      // long hold so the block backs up into its input
      if (seen == 20) stall = LONG_HOLD;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
      seen++;
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
          (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
        idle = 0;
      else
        idle++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    filter_word_t w;
    int frames;
    rst_n               <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.opcode        <= OP_BYTE;
    in_ch.entry_address <= '0;
    in_ch.entry_port    <= '0;
    in_ch.packet_byte   <= '0;
    in_ch.packet_last   <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // one-byte frame on an empty table
    w          = random_word();
    w.opcode   = OP_BYTE;
    w.pkt_byte = 8'h00;
    w.last     = 1'b1;
    send_word(w);
    // all-zero add leaves the entry empty
    send_word(add_word('0, '0));
    send_word(add_word('0, '1));
    send_word(add_word('1, '0));
    // short frame, captures stay zero and zero never matches
    w          = random_word();
    w.opcode   = OP_BYTE;
    w.pkt_byte = 8'hff;
    w.last     = 1'b0;
    send_word(w);
    w.pkt_byte = 8'h00;
    w.last     = 1'b1;
    send_word(w);
    send_word(add_word('1, '1));

    frames = 0;
    while (words_sent < WORD_TARGET) begin
      if ($urandom_range(0, 99) < 35) repeat ($urandom_range(1, 2)) send_word(make_add());
      if (frames == 25) begin
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (scoreboard.pending() != 0);
      end
      send_frame(pick_frame_len(), pick_frame_addr(), pick_frame_port());
      frames++;
    end

    in_ch.valid <= 1'b0;
    while (scoreboard.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (scoreboard.errors == 0 && scoreboard.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* address_port_blacklist_filter.f */
sv/apbf_pkg.sv
sv/apbf_if.sv
sv/apbf_capture.sv
sv/address_port_blacklist_filter.sv
sv/apbf_checker.sv
tb/sv/tb_address_port_blacklist_filter.sv
